@@ src/vmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Vertex matrix transform package
// Shared widths, request and response types and the reset matrix of the
// 4x4 Q16.16 vertex transform.
// -----------------------------------------------------------------------------
package vmt_pkg;

   // Fixed-point format and default fraction width.
   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;

   // Matrix store: eight 64-bit registers, two entries each.
   localparam int MAT_REGS   = 8;
   localparam int MAT_IDX_W  = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 2 * DATA_W;

   // One in Q16.16 for the diagonal of the identity.
   localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;

   // Reset contents, highest register index first.
   localparam logic [MAT_REGS-1:0][CSR_DATA_W-1:0] MAT_RESET = {
      {Q_ONE,  Q_ZERO},   // row 3, columns 3 and 2
      {Q_ZERO, Q_ZERO},   // row 3, columns 1 and 0
      {Q_ZERO, Q_ONE},    // row 2, columns 3 and 2
      {Q_ZERO, Q_ZERO},   // row 2, columns 1 and 0
      {Q_ZERO, Q_ZERO},   // row 1, columns 3 and 2
      {Q_ONE,  Q_ZERO},   // row 1, columns 1 and 0
      {Q_ZERO, Q_ZERO},   // row 0, columns 3 and 2
      {Q_ZERO, Q_ONE}     // row 0, columns 1 and 0
   };

   // Vertex carried by one request.
   typedef struct packed {
      logic signed [DATA_W-1:0] in_x;
      logic signed [DATA_W-1:0] in_y;
      logic signed [DATA_W-1:0] in_z;
      logic signed [DATA_W-1:0] in_w;
   } req_type;

   // Transformed vertex carried by one response.
   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
      logic signed [DATA_W-1:0] out_w;
   } rsp_type;

endpackage
`default_nettype wire

@@ src/vertex_matrix_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Vertex matrix transform
// Multiplies each homogeneous Q16.16 vertex by a configurable 4x4 matrix,
// with full-precision sums, an arithmetic shift and 32-bit saturation.
// -----------------------------------------------------------------------------
// A taken request passes through the product, pair-sum, row-total and output
// registers before its response strobe rises.
// Throughput: one vertex per cycle; the sixteen 32x32 multipliers and the
// two adder stages are fully pipelined, so busy never rises.
// Reset clears every pipeline valid bit and loads the identity matrix.
// Responses cannot be stalled: each is shown for exactly one cycle.
module vertex_matrix_transform
   import vmt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request side
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   // Response side
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   // Register write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PROD_W = 2 * DATA_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   logic accept;

   // Matrix registers
   logic [MAT_REGS-1:0][CSR_DATA_W-1:0] mat_ff, mat_in;

   // Pipeline valid bits
   logic prod_vld_ff, prod_vld_in;
   logic pair_vld_ff, pair_vld_in;
   logic sum_vld_ff,  sum_vld_in;
   logic out_vld_ff,  out_vld_in;

   // Pipeline data
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PROD_W-1:0] prod_in [4][4];
   logic signed [PAIR_W-1:0] pair_ff [4][2];
   logic signed [PAIR_W-1:0] pair_in [4][2];
   logic signed [SUM_W-1:0]  sum_ff  [4];
   logic signed [SUM_W-1:0]  sum_in  [4];
   logic [DATA_W-1:0]        res_ff  [4];
   logic [DATA_W-1:0]        res_in  [4];

   logic signed [DATA_W-1:0] vtx [4];

   // The pipeline never holds requests off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign vtx[0] = req_data.in_x;
   assign vtx[1] = req_data.in_y;
   assign vtx[2] = req_data.in_z;
   assign vtx[3] = req_data.in_w;

   // Register writes; indexes beyond the matrix are dropped.
   always_comb begin
      mat_in = mat_ff;
      if (csr_we && (csr_addr < CSR_IDX_W'(MAT_REGS))) begin
         mat_in[csr_addr[MAT_IDX_W-1:0]] = csr_wdata;
      end
   end

   // Stage one: all sixteen products of matrix entry and vertex component.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = $signed(mat_ff[2 * r + c / 2][(c % 2) * DATA_W +: DATA_W])
                            * vtx[c];
         end
      end
   end

   // Stage two: pairwise sums of products in each row.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         pair_in[r][0] = PAIR_W'(prod_ff[r][0]) + PAIR_W'(prod_ff[r][1]);
         pair_in[r][1] = PAIR_W'(prod_ff[r][2]) + PAIR_W'(prod_ff[r][3]);
      end
   end

   // Stage three: full-precision row totals.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = SUM_W'(pair_ff[r][0]) + SUM_W'(pair_ff[r][1]);
      end
   end

   // Stage four: drop the fraction bits (rounding down) and saturate.
   always_comb begin
      logic signed [SUM_W-1:0] shifted;
      for (int r = 0; r < 4; r++) begin
         shifted = sum_ff[r] >>> FRAC_BITS;
         if ((&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1])) begin
            res_in[r] = shifted[DATA_W-1:0];
         end else if (sum_ff[r][SUM_W-1]) begin
            res_in[r] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            res_in[r] = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   end

   assign prod_vld_in = accept;
   assign pair_vld_in = prod_vld_ff;
   assign sum_vld_in  = pair_vld_ff;
   assign out_vld_in  = sum_vld_ff;

   // Control state and the matrix.
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff      <= MAT_RESET;
         prod_vld_ff <= 1'b0;
         pair_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         mat_ff      <= mat_in;
         prod_vld_ff <= prod_vld_in;
         pair_vld_ff <= pair_vld_in;
         sum_vld_ff  <= sum_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Datapath registers, loaded only when their stage carries a request.
   always_ff @(posedge clock) begin
      if (prod_vld_in) begin
         prod_ff <= prod_in;
      end
      if (pair_vld_in) begin
         pair_ff <= pair_in;
      end
      if (sum_vld_in) begin
         sum_ff <= sum_in;
      end
      if (out_vld_in) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_data.out_x = res_ff[0];
   assign rsp_data.out_y = res_ff[1];
   assign rsp_data.out_z = res_ff[2];
   assign rsp_data.out_w = res_ff[3];

   // Every request taken is followed by a response.
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("response missing four cycles after a request");

   // No response appears without a matching earlier request.
   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("response without a matching request");

   // A write beyond the matrix leaves every register untouched.
   a_bad_index_ignored : assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_addr >= CSR_IDX_W'(MAT_REGS))) |=> $stable(mat_ff))
      else $error("matrix changed by an out-of-range register write");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Vertex matrix transform testbench
// Sends Q16.16 vertices through the 4x4 transform and checks every response
// against a predictor of its own. The reset identity, matrix layout, unused
// register indexes, saturation and rounding are exercised first. Random vertices
// and matrices follow under several request gap rates.
// -----------------------------------------------------------------------------
module testbench;
   import vmt_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [66:0] SAT_HI = 67'sh7FFF_FFFF;
   localparam logic signed [66:0] SAT_LO = -SAT_HI - 67'sd1;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor copy of the matrix registers.
   logic [CSR_DATA_W-1:0] matrix_words [MAT_REGS];
   rsp_type               expected_vertices [$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    gap_pct     = 0;

   vertex_matrix_transform #(.FRAC_BITS(FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Free-running 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop the run if it takes far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Entry of the matrix: even columns in the low half of a register.
   function automatic logic signed [DATA_W-1:0] matrix_entry(input int r, input int c);
      logic [CSR_DATA_W-1:0] word;
      word = matrix_words[r * 2 + c / 2];
      return (c % 2) ? word[63:32] : word[31:0];
   endfunction

   // One row dotted with the vertex at full width, floored shift, then clamped.
   function automatic logic signed [DATA_W-1:0] dot_row(input int r, input req_type v);
      logic signed [DATA_W-1:0] comp [4];
      logic signed [66:0]       acc;
      logic signed [66:0]       lhs;
      logic signed [66:0]       rhs;
      comp[0] = v.in_x;
      comp[1] = v.in_y;
      comp[2] = v.in_z;
      comp[3] = v.in_w;
      acc = '0;
      for (int c = 0; c < 4; c++) begin
         lhs = matrix_entry(r, c);
         rhs = comp[c];
         acc = acc + lhs * rhs;
      end
      acc = acc >>> FRAC;
      if (acc > SAT_HI)
         return 32'h7FFF_FFFF;
      if (acc < SAT_LO)
         return 32'h8000_0000;
      return acc[DATA_W-1:0];
   endfunction

   function automatic rsp_type transform_vertex(input req_type v);
      rsp_type t;
      t.out_x = dot_row(0, v);
      t.out_y = dot_row(1, v);
      t.out_z = dot_row(2, v);
      t.out_w = dot_row(3, v);
      return t;
   endfunction

   // Random Q16.16 value: full range, corner values or modest magnitudes.
   function automatic logic [DATA_W-1:0] random_q();
      case ($urandom_range(7))
         0, 1: return $urandom();
         2: begin
            case ($urandom_range(5))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               4:       return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
         3, 4:    return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
         default: return $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
      endcase
   endfunction

   function automatic req_type random_vertex();
      return {random_q(), random_q(), random_q(), random_q()};
   endfunction

   function automatic logic [15:0][DATA_W-1:0] random_matrix();
      logic [15:0][DATA_W-1:0] entries;
      for (int i = 0; i < 16; i++)
         entries[i] = random_q();
      return entries;
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Every response is compared with the oldest outstanding vertex.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_vertices.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = expected_vertices.pop_front();
            check_field("out_x", want.out_x, rsp_data.out_x);
            check_field("out_y", want.out_y, rsp_data.out_y);
            check_field("out_z", want.out_z, rsp_data.out_z);
            check_field("out_w", want.out_w, rsp_data.out_w);
         end
      end
   end

   // Sends one vertex after a random gap; start is left high for a following request.
   task automatic send_vertex(input req_type v);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (busy);
      expected_vertices.push_back(transform_vertex(v));
   endtask

   // Lowers start and waits until every outstanding response has arrived.
   task automatic drain_requests();
      start <= 1'b0;
      do @(posedge clock); while (expected_vertices.size() != 0);
   endtask

   // Register write; the enable stays high unless this is the last of a burst.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value, input bit last);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx < MAT_REGS)
         matrix_words[idx] = value;
      if (last)
         csr_we <= 1'b0;
   endtask

   // Writes all sixteen entries, row-major, into the eight registers.
   task automatic load_matrix(input logic [15:0][DATA_W-1:0] entries);
      for (int i = 0; i < MAT_REGS; i++)
         write_csr(CSR_IDX_W'(i), {entries[2 * i + 1], entries[2 * i]}, i == MAT_REGS - 1);
   endtask

   task automatic load_uniform(input logic [DATA_W-1:0] value);
      load_matrix({16{value}});
   endtask

   // The identity after reset must pass every vertex through unchanged.
   task automatic test_reset_identity();
      gap_pct = 0;
      send_vertex({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      send_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_vertex({32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000});
      send_vertex({32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0});
      drain_requests();
   endtask

   // Distinct entries and one-hot vertices pick out each column in turn.
   task automatic test_register_layout();
      logic [15:0][DATA_W-1:0] entries;
      for (int i = 0; i < 16; i++)
         entries[i] = (i + 1) << FRAC;
      load_matrix(entries);
      send_vertex({32'h0001_0000, 32'h0, 32'h0, 32'h0});
      send_vertex({32'h0, 32'h0001_0000, 32'h0, 32'h0});
      send_vertex({32'h0, 32'h0, 32'h0001_0000, 32'h0});
      send_vertex({32'h0, 32'h0, 32'h0, 32'h0001_0000});
      drain_requests();
   endtask

   // Writes above the last register must leave the matrix untouched.
   task automatic test_unused_index();
      for (int i = MAT_REGS; i < 16; i++)
         write_csr(CSR_IDX_W'(i), '1, i == 15);
      send_vertex({32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
      drain_requests();
   endtask

   // Clamping in both directions, the widest positive sum and the exact limits.
   task automatic test_saturation();
      load_uniform(32'h7FFF_FFFF);
      send_vertex({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      send_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_vertex({32'h0001_0000, 32'h0, 32'h0, 32'h0});
      drain_requests();
      load_uniform(32'h8000_0000);
      send_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send_vertex({32'h0001_0000, 32'h0, 32'h0, 32'h0});
      drain_requests();
   endtask

   // The shift rounds towards minus infinity.
   task automatic test_rounding();
      load_uniform(32'h0000_0001);
      send_vertex({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_vertex({32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
      send_vertex({32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000});
      drain_requests();
   endtask

   // Random vertices with a fresh random matrix every fifty requests.
   task automatic test_random_traffic(input int pct, input int count);
      gap_pct = pct;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            drain_requests();
            write_csr(CSR_IDX_W'($urandom_range(MAT_REGS, 15)),
                      {$urandom(), $urandom()}, 1'b0);
            load_matrix(random_matrix());
         end
         send_vertex(random_vertex());
      end
      drain_requests();
   endtask

   initial begin
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      // Predictor starts from the identity, as the block does.
      for (int i = 0; i < MAT_REGS; i++)
         matrix_words[i] = '0;
      matrix_words[0] = 64'h0000_0000_0001_0000;
      matrix_words[2] = 64'h0001_0000_0000_0000;
      matrix_words[5] = 64'h0000_0000_0001_0000;
      matrix_words[7] = 64'h0001_0000_0000_0000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_identity();
      test_register_layout();
      test_unused_index();
      test_saturation();
      test_rounding();
      test_random_traffic(0, 200);
      test_random_traffic(52, 200);
      test_random_traffic(32, 200);
      test_random_traffic(0, 200);

      // Wait for any stray response.
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
